// ===== hdl/brt_pkg.sv =====
// Shared constants, types and codes of the buffer range tracker.
package brt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 64;
    localparam int HANDLE_W    = 64;
    localparam int WORDS_W     = 20;
    localparam int KIND_W      = 3;
    localparam int SEL_W       = 5;
    localparam int REQ_BYTES_W = WORDS_W + 2;

    localparam int STATUS_W    = 3;
    localparam int OUT_IDX_W   = 6;
    localparam int OUT_CNT_W   = 6;

    localparam int S_TDATA_W   = 160;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 144;
    localparam int M_TUSER_W   = STATUS_W;

    localparam logic [OUT_IDX_W-1:0] NO_ENTRY = OUT_IDX_W'(TABLE_DEPTH);

    typedef struct packed {
        logic [ADDR_W-1:0]   start;
        logic [HANDLE_W-1:0] handle;
        logic [ADDR_W-1:0]   bytes;
        logic [KIND_W-1:0]   kind;
        logic                copied;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_EXISTS   = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_ERROR    = 3'd3,
        ST_MARKED   = 3'd4,
        ST_REJECTED = 3'd5
    } t_status;

    typedef enum logic {
        MODE_ADD  = 1'b0,
        MODE_MARK = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK_RD,
        S_MARK_CHK,
        S_SCAN,
        S_APPEND,
        S_RESULT
    } t_state;

endpackage

// ===== hdl/brt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module brt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/buffer_range_tracker.sv =====
// Top level of the buffer range tracker: request decode, table scan and result register.
//
// The table of referenced ranges lives in one RAM with a registered read port. An add
// request scans the valid entries in order through that read port, one entry per cycle,
// into a three-stage compare pipeline (read, overlap test, saturating union); a hit that
// grows an entry or an append writes the RAM once at the end. An add can end early
// when a matching entry is found. A zero size add or a mark of an entry not in use goes
// straight to the result. One request is in work at a time; the next is accepted once
// the previous result sits in the output register. Every RAM write completes before
// the next request reads the table, so no forwarding is needed. The table holds no
// reset state beyond the entry count.
module buffer_range_tracker import brt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // gpu_address, host_handle, size_words, buffer_type, entry_select, zero pad
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // mode
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // entry_index, entry_address, entry_bytes, entries_used, zero pad
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // status
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    t_state r_state, n_state;

    logic [ADDR_W-1:0]     r_req_addr;
    logic [HANDLE_W-1:0]   r_req_handle;
    logic [REQ_BYTES_W-1:0] r_req_bytes;
    logic [KIND_W-1:0]     r_req_kind;
    logic [SEL_W-1:0]      r_req_sel;

    logic [CNT_W-1:0]      r_used, n_used;
    logic [CNT_W-1:0]      r_rd_ptr, n_rd_ptr;

    logic                  r_d_valid;
    logic [IDX_W-1:0]      r_d_idx;

    logic                  r1_valid, r1_hit, r1_copied;
    logic [IDX_W-1:0]      r1_idx;
    logic [ADDR_W-1:0]     r1_base, r1_d, r1_add, r1_keep, r1_start, r1_bytes;

    logic                  r2_valid, r2_hit, r2_copied;
    logic [IDX_W-1:0]      r2_idx;
    logic [ADDR_W-1:0]     r2_base, r2_span, r2_keep, r2_start, r2_bytes;

    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [OUT_IDX_W-1:0]  r_res_idx, n_res_idx;
    logic [ADDR_W-1:0]     r_res_addr, n_res_addr;
    logic [ADDR_W-1:0]     r_res_bytes, n_res_bytes;
    logic                  res_load;

    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_tdata;
    logic [M_TUSER_W-1:0]  r_out_tuser;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    t_entry                ram_wdata, ram_q;
    logic [ENTRY_W-1:0]    ram_q_bits;

    logic                  s_accept, out_free, issue, scan_end;
    logic [ADDR_W-1:0]     req_bytes64;
    logic                  e_match, e_ge, e_ova, e_ovb;
    logic [ADDR_W-1:0]     e_dab, e_dba;
    logic [ADDR_W:0]       e_sum;
    logic [ADDR_W-1:0]     e_span, d_us;
    logic                  d_grow, d_last, d_exists, d_update, d_append;
    logic                  in_mode;
    logic [WORDS_W-1:0]    in_words;
    logic [SEL_W-1:0]      in_sel;

    brt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q_bits)
    );

    assign ram_q       = t_entry'(ram_q_bits);
    assign s_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free    = !r_out_valid || i_m_axis_tready;
    assign req_bytes64 = ADDR_W'(r_req_bytes);
    assign in_mode     = i_s_axis_tuser[0];
    assign in_words    = i_s_axis_tdata[147:128];
    assign in_sel      = i_s_axis_tdata[155:151];

    // overlap test on the entry just read
    always_comb begin
        e_match = (ram_q.handle == r_req_handle) && (ram_q.kind == r_req_kind);
        e_ge    = r_req_addr <= ram_q.start;
        e_dab   = ram_q.start - r_req_addr;
        e_dba   = r_req_addr - ram_q.start;
        e_ova   = e_ge && (e_dab < req_bytes64);
        e_ovb   = !e_ge && (e_dba < ram_q.bytes);
    end

    // saturating union span
    always_comb begin
        e_sum  = {1'b0, r1_d} + {1'b0, r1_add};
        e_span = e_sum[ADDR_W] ? '1 : e_sum[ADDR_W-1:0];
    end

    // scan decision
    always_comb begin
        d_us     = (r2_span > r2_keep) ? r2_span : r2_keep;
        d_grow   = r2_bytes < d_us;
        d_last   = CNT_W'(r2_idx) == (r_used - CNT_W'(1));
        d_exists = r2_valid && r2_hit && !d_grow;
        d_update = r2_valid && r2_hit && d_grow && !r2_copied;
        d_append = r2_valid && ((r2_hit && d_grow && r2_copied) || (!r2_hit && d_last));
        scan_end = (r_state == S_SCAN) && (d_exists || d_update || d_append);
        issue    = (r_state == S_SCAN) && (r_rd_ptr < r_used) && !scan_end;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (in_mode == MODE_MARK) begin
                        n_state = (CNT_W'(in_sel) >= r_used) ? S_RESULT : S_MARK_RD;
                    end else if (in_words == '0) begin
                        n_state = S_RESULT;
                    end else if (r_used == '0) begin
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_MARK_RD:  n_state = S_MARK_CHK;
            S_MARK_CHK: n_state = S_RESULT;
            S_SCAN: begin
                if (d_exists || d_update) begin
                    n_state = S_RESULT;
                end else if (d_append) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of each state
    always_comb begin
        o_s_axis_tready = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = r2_idx;
        ram_wdata       = '{start: r2_base, handle: r_req_handle, bytes: d_us,
                            kind: r_req_kind, copied: 1'b0};
        ram_raddr       = r_rd_ptr[IDX_W-1:0];
        res_load        = 1'b0;
        n_res_status    = ST_ERROR;
        n_res_idx       = NO_ENTRY;
        n_res_addr      = '0;
        n_res_bytes     = '0;
        n_used          = r_used;
        n_rd_ptr        = r_rd_ptr;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                n_rd_ptr        = '0;
                if (s_accept) begin
                    if (in_mode == MODE_MARK) begin
                        res_load     = 1'b1;
                        n_res_status = ST_REJECTED;
                    end else if (in_words == '0) begin
                        res_load     = 1'b1;
                        n_res_status = ST_ERROR;
                    end
                end
            end
            S_MARK_RD: begin
                ram_raddr = IDX_W'(r_req_sel);
            end
            S_MARK_CHK: begin
                res_load    = 1'b1;
                n_res_idx   = OUT_IDX_W'(r_req_sel);
                n_res_addr  = ram_q.start;
                n_res_bytes = ram_q.bytes;
                if (ram_q.handle == '0 || ram_q.bytes == '0) begin
                    n_res_status = ST_REJECTED;
                end else begin
                    n_res_status     = ST_MARKED;
                    ram_we           = 1'b1;
                    ram_waddr        = IDX_W'(r_req_sel);
                    ram_wdata        = ram_q;
                    ram_wdata.copied = 1'b1;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_rd_ptr = r_rd_ptr + CNT_W'(1);
                end
                n_res_idx   = OUT_IDX_W'(r2_idx);
                if (d_exists) begin
                    res_load     = 1'b1;
                    n_res_status = ST_EXISTS;
                    n_res_addr   = r2_start;
                    n_res_bytes  = r2_bytes;
                end else if (d_update) begin
                    res_load     = 1'b1;
                    ram_we       = 1'b1;
                    n_res_status = ST_UPDATED;
                    n_res_addr   = r2_base;
                    n_res_bytes  = d_us;
                end
            end
            S_APPEND: begin
                res_load = 1'b1;
                if (r_used >= CNT_W'(TABLE_DEPTH)) begin
                    n_res_status = ST_ERROR;
                end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_used[IDX_W-1:0];
                    ram_wdata    = '{start: r_req_addr, handle: r_req_handle,
                                     bytes: req_bytes64, kind: r_req_kind, copied: 1'b0};
                    n_res_status = ST_ADDED;
                    n_res_idx    = OUT_IDX_W'(r_used);
                    n_res_addr   = r_req_addr;
                    n_res_bytes  = req_bytes64;
                    n_used       = r_used + CNT_W'(1);
                end
            end
            S_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_rd_ptr    <= '0;
            r_d_valid   <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_rd_ptr  <= n_rd_ptr;
            r_d_valid <= issue;
            r1_valid  <= (r_state == S_SCAN) && r_d_valid && !scan_end;
            r2_valid  <= (r_state == S_SCAN) && r1_valid && !scan_end;
            if (r_state == S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request, pipeline and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req_addr   <= i_s_axis_tdata[63:0];
            r_req_handle <= i_s_axis_tdata[127:64];
            r_req_bytes  <= {in_words, 2'b00};
            r_req_kind   <= i_s_axis_tdata[150:148];
            r_req_sel    <= in_sel;
        end
        r_d_idx   <= r_rd_ptr[IDX_W-1:0];
        r1_idx    <= r_d_idx;
        r1_hit    <= e_match && (e_ova || e_ovb);
        r1_base   <= e_ova ? r_req_addr : ram_q.start;
        r1_d      <= e_ova ? e_dab : e_dba;
        r1_add    <= e_ova ? ram_q.bytes : req_bytes64;
        r1_keep   <= e_ova ? req_bytes64 : ram_q.bytes;
        r1_start  <= ram_q.start;
        r1_bytes  <= ram_q.bytes;
        r1_copied <= ram_q.copied;
        r2_idx    <= r1_idx;
        r2_hit    <= r1_hit;
        r2_base   <= r1_base;
        r2_span   <= e_span;
        r2_keep   <= r1_keep;
        r2_start  <= r1_start;
        r2_bytes  <= r1_bytes;
        r2_copied <= r1_copied;
        if (res_load) begin
            r_res_status <= n_res_status;
            r_res_idx    <= n_res_idx;
            r_res_addr   <= n_res_addr;
            r_res_bytes  <= n_res_bytes;
        end
        if (r_state == S_RESULT && out_free) begin
            r_out_tuser <= r_res_status;
            r_out_tdata <= {4'b0000, OUT_CNT_W'(r_used), r_res_bytes, r_res_addr, r_res_idx};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

endmodule
